[rtl/core/sqp_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the
// sorted priority queue. No dependencies.
package sqp_pkg;

  // Queue size and priority width
  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int PRIO_W        = (PRIORITY_BITS < 8) ? PRIORITY_BITS : 8;
  localparam int CNT_W         = $clog2(CAPACITY + 1);
  localparam int VALUE_W       = 32;

  // Command codes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_req;    // latch the incoming request
    logic       capture_cmp; // register the priority compare vector
    logic       do_insert;   // shift entries back and insert
    logic       do_remove;   // shift entries forward, drop the front
    logic       load_result; // load the result register
    logic       show_front;  // report the front entry in the result
    logic [1:0] status;
  } sqp_ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       empty;
  } sqp_stat_t;

endpackage

[rtl/core/sqp_datapath.sv]
// Entry store, insertion compare/shift row and result register of the
// sorted priority queue. Depends on sqp_pkg.
module sqp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sqp_pkg::sqp_ctrl_t            ctrl_i,
  output sqp_pkg::sqp_stat_t            stat_o,
  input  logic [1:0]                    cmd_i,
  input  logic [sqp_pkg::VALUE_W-1:0]   item_value_i,
  input  logic [7:0]                    item_priority_i,
  output logic [1:0]                    status_o,
  output logic [sqp_pkg::VALUE_W-1:0]   front_value_o,
  output logic [7:0]                    front_priority_o,
  output logic                          is_empty_o,
  output logic [sqp_pkg::CNT_W-1:0]     occupancy_o
);
  import sqp_pkg::*;

  logic [VALUE_W-1:0] val_q [CAPACITY];
  logic [VALUE_W-1:0] val_d [CAPACITY];
  logic [PRIO_W-1:0]  pri_q [CAPACITY];
  logic [PRIO_W-1:0]  pri_d [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CAPACITY-1:0] ge_q, ge_d;

  logic [1:0]         op_q;
  logic [VALUE_W-1:0] req_val_q;
  logic [PRIO_W-1:0]  req_pri_q;

  logic [1:0]         res_status_q;
  logic [VALUE_W-1:0] res_val_q;
  logic [7:0]         res_pri_q, res_pri_d;
  logic               res_empty_q;
  logic [CNT_W-1:0]   res_count_q;

  // Latch the request
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      op_q      <= cmd_i;
      req_val_q <= item_value_i;
      req_pri_q <= item_priority_i[PRIO_W-1:0];
    end
  end

  // Compare every live entry against the request priority
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      ge_d[k] = (CNT_W'(k) < count_q) && (pri_q[k] >= req_pri_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture_cmp) begin
      ge_q <= ge_d;
    end
  end

  // Shift row: insert behind the equal-or-higher prefix, or drop the front
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      val_d[k] = val_q[k];
      pri_d[k] = pri_q[k];
    end
    count_d = count_q;
    if (ctrl_i.do_insert) begin
      // front slot takes the request when no entry ranks ahead of it
      if (!ge_q[0]) begin
        val_d[0] = req_val_q;
        pri_d[0] = req_pri_q;
      end
      for (int k = 1; k < CAPACITY; k++) begin
        if (!ge_q[k]) begin
          if (ge_q[k-1]) begin
            val_d[k] = req_val_q;
            pri_d[k] = req_pri_q;
          end else begin
            val_d[k] = val_q[k-1];
            pri_d[k] = pri_q[k-1];
          end
        end
      end
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.do_remove) begin
      for (int k = 0; k < CAPACITY - 1; k++) begin
        val_d[k] = val_q[k+1];
        pri_d[k] = pri_q[k+1];
      end
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CAPACITY; k++) begin
      val_q[k] <= val_d[k];
      pri_q[k] <= pri_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register
  always_comb begin
    res_pri_d = '0;
    res_pri_d[PRIO_W-1:0] = pri_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_result) begin
      res_status_q <= ctrl_i.status;
      res_val_q    <= ctrl_i.show_front ? val_q[0] : '0;
      res_pri_q    <= ctrl_i.show_front ? res_pri_d : '0;
      res_empty_q  <= (count_d == '0);
      res_count_q  <= count_d;
    end
  end

  assign stat_o.op    = op_q;
  assign stat_o.full  = (count_q >= CNT_W'(CAPACITY));
  assign stat_o.empty = (count_q == '0);

  assign status_o         = res_status_q;
  assign front_value_o    = res_val_q;
  assign front_priority_o = res_pri_q;
  assign is_empty_o       = res_empty_q;
  assign occupancy_o      = res_count_q;

endmodule

[rtl/core/sqp_ctrl.sv]
// Sequencing state machine and handshake control of the sorted priority
// queue. Depends on sqp_pkg.
module sqp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  sqp_pkg::sqp_stat_t stat_i,
  output sqp_pkg::sqp_ctrl_t ctrl_o
);
  import sqp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       exec_go;
  logic       accept;

  // Finish a request once the result register is free
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) || exec_go;
  assign accept     = in_valid_i && in_ready_o;

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_CMP;
      end
      S_CMP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (accept) state_d = S_CMP;
        else if (exec_go) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Decode the latched request into datapath actions
  always_comb begin
    ctrl_o             = '0;
    ctrl_o.load_req    = accept;
    ctrl_o.capture_cmp = (state_q == S_CMP);
    ctrl_o.load_result = exec_go;
    ctrl_o.status      = ST_OK;
    if (exec_go) begin
      unique case (stat_i.op)
        OP_ENQ: begin
          if (stat_i.full) ctrl_o.status = ST_FULL;
          else ctrl_o.do_insert = 1'b1;
        end
        OP_DEQ: begin
          if (stat_i.empty) begin
            ctrl_o.status = ST_EMPTY;
          end else begin
            ctrl_o.do_remove  = 1'b1;
            ctrl_o.show_front = 1'b1;
          end
        end
        OP_PEEK: begin
          if (stat_i.empty) ctrl_o.status = ST_EMPTY;
          else ctrl_o.show_front = 1'b1;
        end
        default: begin
          ctrl_o.status = ST_OK;
        end
      endcase
    end
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_go) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/sorted_priority_queue.sv]
// Top level of the sorted priority queue: controller plus datapath.
// Depends on sqp_pkg, sqp_ctrl and sqp_datapath.
//
//   channel  handshake               payload
//   in       in_valid_i/in_ready_o   cmd_i, item_value_i, item_priority_i
//   out      out_valid_o/out_ready_i status_o, front_value_o, front_priority_o,
//                                    is_empty_o, occupancy_o
//
// Each request first registers the priority compare over all entries, then
// shifts the entry row and loads the result register. A new request is taken
// in the cycle that finishes the previous one, as long as results are taken.
// While a result is still waiting, the request in hand holds in its final
// cycle and no further request is taken; an idle queue still takes one.
// Reset empties the queue; entry contents are not cleared.
module sorted_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [sqp_pkg::VALUE_W-1:0] item_value_i,
  input  logic [7:0]                  item_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [sqp_pkg::VALUE_W-1:0] front_value_o,
  output logic [7:0]                  front_priority_o,
  output logic                        is_empty_o,
  output logic [sqp_pkg::CNT_W-1:0]   occupancy_o
);
  import sqp_pkg::*;

  sqp_ctrl_t ctrl;
  sqp_stat_t stat;

  sqp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  sqp_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .cmd_i            (cmd_i),
    .item_value_i     (item_value_i),
    .item_priority_i  (item_priority_i),
    .status_o         (status_o),
    .front_value_o    (front_value_o),
    .front_priority_o (front_priority_o),
    .is_empty_o       (is_empty_o),
    .occupancy_o      (occupancy_o)
  );

endmodule

[tb/pq_result_checker.sv]
// Result checker for the sorted priority queue: predicts each result from the
// accepted requests and compares it with the result taken from the block.
// Depends on sqp_pkg.
module pq_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic [1:0]                  req_cmd_i,
  input  logic [sqp_pkg::VALUE_W-1:0] req_value_i,
  input  logic [7:0]                  req_prio_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  logic [1:0]                  rsp_status_i,
  input  logic [sqp_pkg::VALUE_W-1:0] rsp_value_i,
  input  logic [7:0]                  rsp_prio_i,
  input  logic                        rsp_empty_i,
  input  logic [sqp_pkg::CNT_W-1:0]   rsp_count_i,
  output int                          mismatch_count_o,
  output int                          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sqp_pkg::*;

  localparam logic [7:0] PRIO_MASK =
    (PRIORITY_BITS >= 8) ? 8'hFF : 8'((1 << PRIORITY_BITS) - 1);

  typedef struct packed {
    logic [1:0]         status;
    logic [VALUE_W-1:0] value;
    logic [7:0]         prio;
    logic               empty;
    logic [CNT_W-1:0]   count;
  } queue_result_t;

  // Shadow copy of the queue contents, front entry at index 0
  logic [VALUE_W-1:0] held_value [CAPACITY];
  logic [7:0]         held_prio  [CAPACITY];
  int                 held_count;

  queue_result_t awaited_results [$];

  // Apply one request to the shadow queue and return the result it gives
  function automatic queue_result_t apply_command(input logic [1:0] cmd,
                                                  input logic [VALUE_W-1:0] value,
                                                  input logic [7:0] prio);
    queue_result_t res;
    logic [7:0]    key;
    int            slot;
    int            k;
    res = '0;
    key = prio & PRIO_MASK;
    case (cmd)
      OP_ENQ: begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // insert behind every entry of equal or higher priority
          slot = 0;
          while (slot < held_count && held_prio[slot] >= key) slot++;
          for (k = held_count; k > slot; k--) begin
            held_value[k] = held_value[k-1];
            held_prio[k]  = held_prio[k-1];
          end
          held_value[slot] = value;
          held_prio[slot]  = key;
          held_count++;
          res.status = ST_OK;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_OK;
          res.value  = held_value[0];
          res.prio   = held_prio[0];
          // advance the remaining entries on a dequeue only
          if (cmd == OP_DEQ) begin
            for (k = 1; k < held_count; k++) begin
              held_value[k-1] = held_value[k];
              held_prio[k-1]  = held_prio[k];
            end
            held_count--;
          end
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.empty = (held_count == 0);
    res.count = CNT_W'(held_count);
    return res;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %h, got %h", $time, label, want, got);
      mismatch_count_o++;
    end
  endtask

  // Compare the taken result before logging a new request: a request accepted
  // at this edge cannot have produced a result yet
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    queue_result_t want;
    if (!rst_ni) begin
      held_count       = 0;
      mismatch_count_o = 0;
      awaited_results.delete();
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with none awaited, expected none, got status %h",
                   $time, rsp_status_i);
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_status_i));
          check_field("front_value", want.value, rsp_value_i);
          check_field("front_priority", 32'(want.prio), 32'(rsp_prio_i));
          check_field("is_empty", 32'(want.empty), 32'(rsp_empty_i));
          check_field("occupancy", 32'(want.count), 32'(rsp_count_i));
        end
      end
      if (req_valid_i && req_ready_i)
        awaited_results.push_back(apply_command(req_cmd_i, req_value_i, req_prio_i));
    end
    outstanding_o = awaited_results.size();
  end

endmodule

[tb/testbench.sv]
// Top of the sorted priority queue testbench: clock, reset, request and
// result traffic, and the verdict. Depends on sqp_pkg, sorted_priority_queue
// and pq_result_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sqp_pkg::*;

  // Unused command code: the block must leave the queue alone
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_REQUESTS = 1700;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [VALUE_W-1:0] item_value_i;
  logic [7:0]         item_priority_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [VALUE_W-1:0] front_value_o;
  logic [7:0]         front_priority_o;
  logic               is_empty_o;
  logic [CNT_W-1:0]   occupancy_o;

  int mismatch_count;
  int outstanding;
  int sender_gap_max;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_priority_queue uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .item_value_i     (item_value_i),
    .item_priority_i  (item_priority_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .front_value_o    (front_value_o),
    .front_priority_o (front_priority_o),
    .is_empty_o       (is_empty_o),
    .occupancy_o      (occupancy_o)
  );

  pq_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (in_valid_i),
    .req_ready_i      (in_ready_o),
    .req_cmd_i        (cmd_i),
    .req_value_i      (item_value_i),
    .req_prio_i       (item_priority_i),
    .rsp_valid_i      (out_valid_o),
    .rsp_ready_i      (out_ready_i),
    .rsp_status_i     (status_o),
    .rsp_value_i      (front_value_o),
    .rsp_prio_i       (front_priority_o),
    .rsp_empty_i      (is_empty_o),
    .rsp_count_i      (occupancy_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // Offer one request after a random gap and hold it until it is accepted
  task automatic send_request(input logic [1:0] cmd, input logic [VALUE_W-1:0] value,
                              input logic [7:0] prio);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= cmd;
    item_value_i    <= value;
    item_priority_i <= prio;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Draw a random request; enq_share sets how hard the queue is pushed to fill
  task automatic send_random_request(input int enq_share);
    int         roll;
    logic [1:0] cmd;
    logic [7:0] prio;
    roll = $urandom_range(0, 99);
    if (roll < 3)                  cmd = OP_SPARE;
    else if (roll < 3 + enq_share) cmd = OP_ENQ;
    else if (roll < 88)            cmd = OP_DEQ;
    else                           cmd = OP_PEEK;
    // bias towards a few priorities so that ties are common
    roll = $urandom_range(0, 99);
    if (roll < 40)      prio = 8'($urandom_range(0, 3));
    else if (roll < 50) prio = (roll < 45) ? 8'd0 : 8'd255;
    else                prio = 8'($urandom_range(0, 255));
    send_request(cmd, $urandom, prio);
  endtask

  // Take results after random gaps, with one long hold-off to back up the queue
  initial begin : take_results
    int gap;
    int taken;
    taken = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken == 400)                gap = 150;
      else if ((taken / 80) % 3 == 1)  gap = 0;
      else                             gap = $urandom_range(0, 7);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Main request sequence and verdict
  initial begin : drive_requests
    int n;
    int phase;
    in_valid_i      <= 1'b0;
    cmd_i           <= OP_PEEK;
    item_value_i    <= '0;
    item_priority_i <= '0;
    sender_gap_max  = 7;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue: peek, dequeue and the spare code
    send_request(OP_PEEK, 32'h1234_5678, 8'd9);
    send_request(OP_DEQ, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_SPARE, 32'hA5A5_A5A5, 8'h5A);
    // extremes of value and priority, with ties behind each other
    send_request(OP_ENQ, 32'h7FFF_FFFF, 8'd0);
    send_request(OP_ENQ, 32'h8000_0000, 8'd255);
    send_request(OP_ENQ, 32'h0000_0000, 8'd255);
    send_request(OP_ENQ, 32'hFFFF_FFFF, 8'd128);
    send_request(OP_PEEK, 32'h0, 8'd0);
    for (n = 0; n < 12; n++)
      send_request(OP_ENQ, $urandom, 8'((n % 3) * 100));
    // full queue: drop an enqueue, then spare code, peek and dequeue
    send_request(OP_ENQ, 32'hDEAD_BEEF, 8'd255);
    send_request(OP_SPARE, 32'h0, 8'd0);
    send_request(OP_PEEK, 32'h0, 8'd0);
    send_request(OP_DEQ, 32'h0, 8'd0);

    // random phases alternate filling and draining, some back to back
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      phase = n / 100;
      sender_gap_max = (phase % 4 == 3) ? 0 : 7;
      case (phase % 3)
        0:       send_random_request(50);
        1:       send_random_request(75);
        default: send_random_request(30);
      endcase
    end
    in_valid_i <= 1'b0;

    // drain, then wait for any stray result
    do @(negedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
